// ===== design/cubic_bspline_curve_tessellator_unit_macros.svh =====
// Assertion macros for the B-spline tessellator checker.
// No dependencies; included by the checker file.
`ifndef CUBIC_BSPLINE_CURVE_TESSELLATOR_UNIT_MACROS_SVH
`define CUBIC_BSPLINE_CURVE_TESSELLATOR_UNIT_MACROS_SVH

// same-cycle implication, reset disables
`define CBT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset disables
`define CBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/cbt_pkg.sv =====
// Shared constants, command struct and helpers for the B-spline tessellator.
// No dependencies; imported by cbt_ctrl, cbt_datapath and the top level.
package cbt_pkg;

    localparam int DEF_MAX_SEGMENTS = 16;
    localparam int SEG_W            = 5;
    localparam logic [SEG_W-1:0] SEG_RESET = 5'd4;

    localparam int COORD_W = 32;
    localparam int WGT_W   = 16;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = COORD_W + WGT_W + 1;
    localparam int ACC_W   = PROD_W + 2;
    localparam int Q_W     = ACC_W - FRAC_W;

    localparam int N_TERMS = 4;
    localparam int TERM_W  = 2;
    localparam int KW      = $clog2(N_TERMS + 1);

    // weights at t = 0: 1/6, 4/6, 1/6, 0 in Q0.16, rounded
    localparam logic [WGT_W-1:0] W_T0_OUTER = 16'd10923;
    localparam logic [WGT_W-1:0] W_T0_INNER = 16'd43691;

    function automatic int eff_max(input int max_seg);
        int reg_max;
        reg_max = (2 ** SEG_W) - 1;
        return (max_seg < reg_max) ? max_seg : reg_max;
    endfunction

    typedef struct packed {
        logic              load_pt;
        logic              fill_win;
        logic              shift_win;
        logic              rom_rd;
        logic              wt_j0;
        logic              mul_en;
        logic [TERM_W-1:0] mul_sel;
        logic              mac_clr;
        logic              mac_en;
        logic              out_load;
        logic              out_last;
    } t_dp_cmd;

endpackage

// ===== design/cbt_datapath.sv =====
// Datapath: point window, weight ROM, three shared multipliers, accumulators,
// rounding/saturation and output register. Depends on cbt_pkg.
module cbt_datapath import cbt_pkg::*; #(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    localparam int NMAX = eff_max(MAX_SEGMENTS),
    localparam int IW   = (NMAX > 1) ? $clog2(NMAX) : 1
) (
    input  logic                      i_clk,
    input  t_dp_cmd                   i_cmd,
    input  logic [IW-1:0]             i_n_idx,
    input  logic [IW-1:0]             i_j_idx,
    input  logic signed [COORD_W-1:0] i_px,
    input  logic signed [COORD_W-1:0] i_py,
    input  logic signed [COORD_W-1:0] i_pz,
    output logic signed [COORD_W-1:0] o_cx,
    output logic signed [COORD_W-1:0] o_cy,
    output logic signed [COORD_W-1:0] o_cz,
    output logic                      o_end_of_curve
);

    // weight table, indexed [N-1][j-1], packed {w3, w2, w1, w0}
    logic [N_TERMS*WGT_W-1:0] w_rom [NMAX][NMAX];

    for (genvar gn = 0; gn < NMAX; gn++) begin : g_n
        for (genvar gj = 0; gj < NMAX; gj++) begin : g_j
            localparam longint NN  = longint'(gn) + 1;
            localparam longint JJ  = longint'(gj) + 1;
            localparam longint DEN = 6 * NN * NN * NN;
            localparam longint KK  = (JJ <= NN) ? (NN - JJ) : 0;
            localparam longint N0  = KK * KK * KK;
            localparam longint N1  = (JJ <= NN) ?
                (3 * JJ * JJ * JJ - 6 * JJ * JJ * NN + 4 * NN * NN * NN) : 0;
            localparam longint N2  = (JJ <= NN) ?
                (-3 * JJ * JJ * JJ + 3 * JJ * JJ * NN + 3 * JJ * NN * NN
                 + NN * NN * NN) : 0;
            localparam longint N3  = (JJ <= NN) ? (JJ * JJ * JJ) : 0;
            localparam longint W0  = (N0 * 131072 + DEN) / (2 * DEN);
            localparam longint W1  = (N1 * 131072 + DEN) / (2 * DEN);
            localparam longint W2  = (N2 * 131072 + DEN) / (2 * DEN);
            localparam longint W3  = (N3 * 131072 + DEN) / (2 * DEN);
            assign w_rom[gn][gj] = {WGT_W'(W3), WGT_W'(W2), WGT_W'(W1), WGT_W'(W0)};
        end
    end

    logic signed [COORD_W-1:0] r_win [3][3];
    logic signed [COORD_W-1:0] r_e [3];
    logic [WGT_W-1:0]          r_wt [N_TERMS];
    logic signed [PROD_W-1:0]  r_prod [3];
    logic signed [ACC_W-1:0]   r_acc [3];
    logic signed [COORD_W-1:0] r_out [3];
    logic                      r_last;

    logic signed [COORD_W-1:0] w_in [3];
    logic signed [COORD_W-1:0] w_opnd [3];
    logic [WGT_W-1:0]          w_wsel;
    logic [ACC_W-1:0]          w_rnd [3];
    logic [Q_W-1:0]            w_q [3];
    logic [Q_W-COORD_W:0]      w_top [3];
    logic signed [COORD_W-1:0] w_sat [3];

    assign w_in[0] = i_px;
    assign w_in[1] = i_py;
    assign w_in[2] = i_pz;

    always_comb begin
        w_wsel = r_wt[i_cmd.mul_sel];
        for (int c = 0; c < 3; c++) begin
            case (i_cmd.mul_sel)
                2'd0: begin
                    w_opnd[c] = r_win[0][c];
                end
                2'd1: begin
                    w_opnd[c] = r_win[1][c];
                end
                2'd2: begin
                    w_opnd[c] = r_win[2][c];
                end
                default: begin
                    w_opnd[c] = r_e[c];
                end
            endcase
        end
    end

    // round half up to Q16.16, then clamp to 32-bit signed
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_rnd[c] = r_acc[c] + ACC_W'(1 << (FRAC_W - 1));
            w_q[c]   = w_rnd[c][ACC_W-1:FRAC_W];
            w_top[c] = w_q[c][Q_W-1:COORD_W-1];
            if ((&w_top[c]) || !(|w_top[c])) begin
                w_sat[c] = w_q[c][COORD_W-1:0];
            end else if (w_q[c][Q_W-1]) begin
                w_sat[c] = {1'b1, {(COORD_W-1){1'b0}}};
            end else begin
                w_sat[c] = {1'b0, {(COORD_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            if (i_cmd.load_pt) begin
                r_e[c] <= w_in[c];
            end
            if (i_cmd.fill_win) begin
                r_win[0][c] <= w_in[c];
                r_win[1][c] <= w_in[c];
                r_win[2][c] <= w_in[c];
            end else if (i_cmd.shift_win) begin
                r_win[0][c] <= r_win[1][c];
                r_win[1][c] <= r_win[2][c];
                r_win[2][c] <= r_e[c];
            end
            if (i_cmd.mul_en) begin
                r_prod[c] <= $signed({1'b0, w_wsel}) * w_opnd[c];
            end
            if (i_cmd.mac_clr) begin
                r_acc[c] <= '0;
            end else if (i_cmd.mac_en) begin
                r_acc[c] <= r_acc[c] + {{(ACC_W-PROD_W){r_prod[c][PROD_W-1]}}, r_prod[c]};
            end
            if (i_cmd.out_load) begin
                r_out[c] <= w_sat[c];
            end
        end
        if (i_cmd.rom_rd) begin
            if (i_cmd.wt_j0) begin
                r_wt[0] <= W_T0_OUTER;
                r_wt[1] <= W_T0_INNER;
                r_wt[2] <= W_T0_OUTER;
                r_wt[3] <= '0;
            end else begin
                for (int k = 0; k < N_TERMS; k++) begin
                    r_wt[k] <= w_rom[i_n_idx][i_j_idx][k*WGT_W +: WGT_W];
                end
            end
        end
        if (i_cmd.out_load) begin
            r_last <= i_cmd.out_last;
        end
    end

    assign o_cx           = r_out[0];
    assign o_cy           = r_out[1];
    assign o_cz           = r_out[2];
    assign o_end_of_curve = r_last;

endmodule

// ===== design/cbt_ctrl.sv =====
// Controller: handshakes, segment register, span/sample/term sequencing.
// Depends on cbt_pkg; drives cbt_datapath through t_dp_cmd.
module cbt_ctrl import cbt_pkg::*; #(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    localparam int NMAX = eff_max(MAX_SEGMENTS),
    localparam int IW   = (NMAX > 1) ? $clog2(NMAX) : 1,
    localparam int CW   = $clog2(NMAX + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_final_point,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [SEG_W-1:0] i_segments_per_span,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_dp_cmd          o_cmd,
    output logic [IW-1:0]    o_n_idx,
    output logic [IW-1:0]    o_j_idx
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ROM  = 2'd1;
    localparam logic [1:0] S_MAC  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;
    localparam logic [KW-1:0] K_LAST = KW'(N_TERMS);

    logic [1:0]       r_state, n_state;
    logic [KW-1:0]    r_k, n_k;
    logic [CW-1:0]    r_j, n_j;
    logic [CW-1:0]    r_n, n_n;
    logic [1:0]       r_spans, n_spans;
    logic             r_fin, n_fin;
    logic             r_first, n_first;
    logic             r_seen, n_seen;
    logic             r_ov, n_ov;
    logic [SEG_W-1:0] r_seg, n_seg;

    logic [SEG_W-1:0] w_seg_clamp;
    logic [CW-1:0]    w_nm1;
    logic [CW-1:0]    w_jm1;
    logic             w_span_end;
    logic             w_out_free;

    assign w_seg_clamp = (r_seg == '0) ? SEG_W'(1) :
                         (r_seg > SEG_W'(NMAX)) ? SEG_W'(NMAX) : r_seg;
    assign w_nm1       = r_n - CW'(1);
    assign w_jm1       = r_first ? '0 : (r_j - CW'(1));
    assign w_span_end  = r_first || (r_j == r_n);
    assign w_out_free  = !r_ov || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_j     = r_j;
        n_n     = r_n;
        n_spans = r_spans;
        n_fin   = r_fin;
        n_first = r_first;
        n_seen  = r_seen;
        n_ov    = r_ov;
        n_seg   = r_seg;
        o_cmd   = '0;
        if (i_cfg_valid) begin
            n_seg = i_segments_per_span;
        end
        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_pt = 1'b1;
                    n_n     = w_seg_clamp[CW-1:0];
                    n_fin   = i_final_point;
                    n_spans = i_final_point ? 2'd2 : 2'd0;
                    if (!r_seen) begin
                        // first point: lone t = 0 sample
                        o_cmd.fill_win = 1'b1;
                        n_first = 1'b1;
                        n_j     = '0;
                        n_seen  = 1'b1;
                    end else begin
                        n_first = 1'b0;
                        n_j     = CW'(1);
                    end
                    n_state = S_ROM;
                end
            end
            S_ROM: begin
                o_cmd.rom_rd = 1'b1;
                o_cmd.wt_j0  = r_first;
                n_k     = '0;
                n_state = S_MAC;
            end
            S_MAC: begin
                o_cmd.mul_en  = (r_k < K_LAST);
                o_cmd.mul_sel = r_k[TERM_W-1:0];
                o_cmd.mac_clr = (r_k == '0);
                o_cmd.mac_en  = (r_k != '0);
                n_k = r_k + KW'(1);
                if (r_k == K_LAST) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = r_fin && (r_spans == 2'd0) && w_span_end;
                    n_ov = 1'b1;
                    if (!w_span_end) begin
                        n_j     = r_j + CW'(1);
                        n_state = S_ROM;
                    end else begin
                        if (!r_first) begin
                            o_cmd.shift_win = 1'b1;
                        end
                        if (r_spans != 2'd0) begin
                            // trailing pad spans
                            n_spans = r_spans - 2'd1;
                            n_j     = CW'(1);
                            n_first = 1'b0;
                            n_state = S_ROM;
                        end else begin
                            if (r_fin) begin
                                n_seen = 1'b0;
                            end
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_j     <= '0;
            r_n     <= CW'(1);
            r_spans <= '0;
            r_fin   <= 1'b0;
            r_first <= 1'b0;
            r_seen  <= 1'b0;
            r_ov    <= 1'b0;
            r_seg   <= SEG_RESET;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_j     <= n_j;
            r_n     <= n_n;
            r_spans <= n_spans;
            r_fin   <= n_fin;
            r_first <= n_first;
            r_seen  <= n_seen;
            r_ov    <= n_ov;
            r_seg   <= n_seg;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ov;
    assign o_n_idx     = w_nm1[IW-1:0];
    assign o_j_idx     = w_jm1[IW-1:0];

endmodule

// ===== design/cubic_bspline_curve_tessellator_unit.sv =====
// Top level of the uniform cubic B-spline tessellator (3D, Q16.16).
// Depends on cbt_pkg, cbt_ctrl and cbt_datapath.
//
// Takes one control point per beat and returns curve samples. Each sample
// passes one weight-table read, four multiply terms through three
// shared 17x32 multipliers (one per axis) plus an accumulate drain, and a
// load of the output register; accepting the point is one more step. With
// N the segment count after clamping to 1..MAX_SEGMENTS (at most 31), an
// inner point yields N samples, the first point of a curve one sample and
// a final point 2*N more, each of which the output may hold off. The
// next point is taken while the last sample still waits in the output
// register. The segment register may be written at any time the block is
// idle and never stalls.
module cubic_bspline_curve_tessellator_unit import cbt_pkg::*; #(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [COORD_W-1:0] i_px,
    input  logic signed [COORD_W-1:0] i_py,
    input  logic signed [COORD_W-1:0] i_pz,
    input  logic                      i_final_point,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [SEG_W-1:0]          i_segments_per_span,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [COORD_W-1:0] o_cx,
    output logic signed [COORD_W-1:0] o_cy,
    output logic signed [COORD_W-1:0] o_cz,
    output logic                      o_end_of_curve
);

    localparam int NMAX = eff_max(MAX_SEGMENTS);
    localparam int IW   = (NMAX > 1) ? $clog2(NMAX) : 1;

    t_dp_cmd       w_cmd;
    logic [IW-1:0] w_n_idx;
    logic [IW-1:0] w_j_idx;

    cbt_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_final_point       (i_final_point),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_segments_per_span (i_segments_per_span),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_cmd               (w_cmd),
        .o_n_idx             (w_n_idx),
        .o_j_idx             (w_j_idx)
    );

    cbt_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .i_n_idx        (w_n_idx),
        .i_j_idx        (w_j_idx),
        .i_px           (i_px),
        .i_py           (i_py),
        .i_pz           (i_pz),
        .o_cx           (o_cx),
        .o_cy           (o_cy),
        .o_cz           (o_cz),
        .o_end_of_curve (o_end_of_curve)
    );

endmodule

// ===== design/cbt_checker.sv =====
// Port-level checker for the B-spline tessellator, bound to the top level.
// Depends on cubic_bspline_curve_tessellator_unit_macros.svh.
`include "cubic_bspline_curve_tessellator_unit_macros.svh"

module cbt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_cx,
    input logic [31:0] o_cy,
    input logic [31:0] o_cz,
    input logic        o_end_of_curve
);

    `CBT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_cx) && $stable(o_cy) && $stable(o_cz)
        && $stable(o_end_of_curve), "stalled output beat changed")
    `CBT_ASSERT_NEXT(a_busy_after_point, i_clk, i_rst_n, i_in_valid && o_in_ready,
        !o_in_ready, "input ready right after a point beat")
    `CBT_ASSERT_NEXT(a_idle_holds, i_clk, i_rst_n, o_in_ready && !i_in_valid,
        o_in_ready, "left idle without an input beat")
    `CBT_ASSERT_SAME(a_cfg_open, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready,
        "config write stalled")

endmodule

bind cubic_bspline_curve_tessellator_unit cbt_checker u_cbt_checker (.*);

// ===== tb/sv/tb_cubic_bspline_curve_tessellator_unit.sv =====
// Self-checking testbench for cubic_bspline_curve_tessellator_unit.
// Holds a B-spline sample predictor in a small scoreboard class and drives
// directed and random control-point beats; depends on cbt_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_cubic_bspline_curve_tessellator_unit;
    import cbt_pkg::*;

    localparam int SPAN_MAX    = DEF_MAX_SEGMENTS;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;

    typedef logic [2:0][COORD_W-1:0] point_t;

    typedef struct packed {
        point_t c;
        logic   eoc;
    } curve_sample_t;

    class curve_sample_board;
        point_t           win [3];
        bit               curve_open;
        logic [SEG_W-1:0] seg_reg;
        curve_sample_t    pending [$];
        int               mismatches;

        function new();
            seg_reg    = SEG_RESET;
            mismatches = 0;
            close_curve();
        endfunction

        function void close_curve();
            for (int i = 0; i < 3; i++) begin
                win[i] = '0;
            end
            curve_open = 1'b0;
        endfunction

        // Q0.16 basis weight, round half up
        function longint q216_weight(longint num, longint den);
            return (num * 131072 + den) / (2 * den);
        endfunction

        function void add_sample(point_t a, point_t b, point_t c, point_t d,
                                 longint n, longint j, bit last);
            longint        den;
            longint        w0, w1, w2, w3;
            longint        acc, q;
            curve_sample_t s;
            den = 6 * n * n * n;
            w0  = q216_weight((n - j) * (n - j) * (n - j), den);
            w1  = q216_weight(3 * j * j * j - 6 * j * j * n + 4 * n * n * n, den);
            w2  = q216_weight(-3 * j * j * j + 3 * j * j * n + 3 * j * n * n + n * n * n,
                              den);
            w3  = q216_weight(j * j * j, den);
            for (int k = 0; k < 3; k++) begin
                acc = w0 * longint'($signed(a[k])) + w1 * longint'($signed(b[k]))
                    + w2 * longint'($signed(c[k])) + w3 * longint'($signed(d[k]));
                q = (acc + 32768) >>> 16;
                if (q > longint'(32'sh7fff_ffff)) q = longint'(32'sh7fff_ffff);
                if (q < longint'(32'sh8000_0000)) q = longint'(32'sh8000_0000);
                s.c[k] = q[31:0];
            end
            s.eoc = last;
            pending.push_back(s);
        endfunction

        function void add_span(point_t e, longint n, bit last_span);
            for (longint j = 1; j <= n; j++) begin
                add_sample(win[0], win[1], win[2], e, n, j, last_span && (j == n));
            end
            win[0] = win[1];
            win[1] = win[2];
            win[2] = e;
        endfunction

        function void take_point(point_t e, bit fin);
            longint n;
            n = seg_reg;
            if (n < 1) n = 1;
            if (n > SPAN_MAX) n = SPAN_MAX;
            if (!curve_open) begin
                win[0]     = e;
                win[1]     = e;
                win[2]     = e;
                curve_open = 1'b1;
                add_sample(e, e, e, e, n, 0, 1'b0);
            end else begin
                add_span(e, n, 1'b0);
            end
            if (fin) begin
                add_span(e, n, 1'b0);
                add_span(e, n, 1'b1);
                close_curve();
            end
        endfunction

        function void match_sample(curve_sample_t got);
            curve_sample_t want;
            if (pending.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected sample: x=%h y=%h z=%h end=%b",
                             got.c[0], got.c[1], got.c[2], got.eoc);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (got.c[0] !== want.c[0] || got.c[1] !== want.c[1] ||
                got.c[2] !== want.c[2] || got.eoc !== want.eoc) begin
                if (mismatches < 10)
                    $display("sample mismatch: exp x=%h y=%h z=%h end=%b, got x=%h y=%h z=%h end=%b",
                             want.c[0], want.c[1], want.c[2], want.eoc,
                             got.c[0], got.c[1], got.c[2], got.eoc);
                mismatches++;
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic signed [COORD_W-1:0] i_px;
    logic signed [COORD_W-1:0] i_py;
    logic signed [COORD_W-1:0] i_pz;
    logic                      i_final_point;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [SEG_W-1:0]          i_segments_per_span;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic signed [COORD_W-1:0] o_cx;
    logic signed [COORD_W-1:0] o_cy;
    logic signed [COORD_W-1:0] o_cz;
    logic                      o_end_of_curve;

    curve_sample_board board = new();
    bit                calm;
    logic              hold_req;
    int                cycle_count = 0;

    cubic_bspline_curve_tessellator_unit #(
        .MAX_SEGMENTS(SPAN_MAX)
    ) uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_px                (i_px),
        .i_py                (i_py),
        .i_pz                (i_pz),
        .i_final_point       (i_final_point),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_segments_per_span (i_segments_per_span),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_cx                (o_cx),
        .o_cy                (o_cy),
        .o_cz                (o_cz),
        .o_end_of_curve      (o_end_of_curve)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [COORD_W-1:0] pick_coord();
        logic [COORD_W-1:0] corner_vals [4];
        corner_vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff};
        if ($urandom_range(7) == 0) return corner_vals[$urandom_range(3)];
        return $urandom;
    endfunction

    // valid stays up after a beat; the next call either idles or re-offers
    task automatic send_point(input point_t p, input logic fin);
        while (!calm && $urandom_range(99) < 26) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_px          <= p[0];
        i_py          <= p[1];
        i_pz          <= p[2];
        i_final_point <= fin;
        do @(posedge i_clk); while (!o_in_ready);
        board.take_point(p, fin);
    endtask

    task automatic write_segments(input logic [SEG_W-1:0] v);
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        i_cfg_valid         <= 1'b1;
        i_segments_per_span <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        board.seg_reg = v;
    endtask

    // output side: random stalls plus one long hold-off
    initial begin
        bit            hold_taken;
        int            hold_left;
        curve_sample_t got;
        hold_taken  = 1'b0;
        hold_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got.c[0] = o_cx;
                got.c[1] = o_cy;
                got.c[2] = o_cz;
                got.eoc  = o_end_of_curve;
                board.match_sample(got);
            end
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= calm || ($urandom_range(99) >= 26);
            end
        end
    end

    initial begin
        point_t           p;
        int               n_items;
        int               left_in_curve;
        logic [SEG_W-1:0] seg_plan [5];
        logic [SEG_W-1:0] seg_val;
        seg_plan            = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd17};
        calm                = 1'b0;
        hold_req            = 1'b0;
        i_rst_n             = 1'b0;
        i_in_valid          = 1'b0;
        i_px                = '0;
        i_py                = '0;
        i_pz                = '0;
        i_final_point       = 1'b0;
        i_cfg_valid         = 1'b0;
        i_segments_per_span = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed beats at the reset segment count
        send_point({3{32'h7fff_ffff}}, 1'b1);
        send_point({3{32'h8000_0000}}, 1'b1);
        send_point({32'h0, 32'h0, 32'h0}, 1'b0);
        send_point({32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001}, 1'b0);
        send_point({32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff}, 1'b0);
        send_point({32'hffff_ffff, 32'h0001_0000, 32'h7fff_8000}, 1'b1);
        repeat (3) send_point({3{32'h7fff_ffff}}, 1'b0);
        send_point({3{32'h7fff_ffff}}, 1'b1);
        repeat (2) send_point({3{32'h8000_0000}}, 1'b0);
        send_point({3{32'h8000_0000}}, 1'b1);
        send_point({32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff}, 1'b0);
        send_point({32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000}, 1'b1);
        send_point({32'h0000_0001, 32'h0000_0002, 32'h0000_0003}, 1'b0);

        left_in_curve = 0;
        for (int ph = 0; ph < 8; ph++) begin
            seg_val = (ph < 5) ? seg_plan[ph] : SEG_W'($urandom_range(31));
            write_segments(seg_val);
            if (ph == 1) hold_req <= 1'b1;
            calm    = (ph == 4);
            n_items = $urandom_range(15, 23);
            for (int i = 0; i < n_items; i++) begin
                if (left_in_curve == 0) left_in_curve = $urandom_range(1, 8);
                p[0] = pick_coord();
                p[1] = pick_coord();
                p[2] = pick_coord();
                left_in_curve--;
                send_point(p, left_in_curve == 0);
            end
        end
        i_in_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
